@@ rtl/puru_pkg.sv @@
package puru_pkg;

  // Row store geometry.
  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned AddrW     = $clog2(MaxWidth);
  localparam int unsigned CntW      = $clog2(MaxWidth + 1);

  // Frame height and replication limits.
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned RowW      = $clog2(MaxHeight);
  localparam int unsigned MaxScale  = 16;
  localparam int unsigned RepW      = $clog2(MaxScale);

  // Field widths.
  localparam int unsigned PixW      = 8;
  localparam int unsigned CfgDataW  = 9;
  localparam int unsigned CfgAddrW  = 2;
  localparam int unsigned UserOutW  = 3;

  // Queue between the front and the back.
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [0:0] {
    CMD_LOAD    = 1'b0,
    CMD_REQUEST = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_STORED    = 2'd0,
    ST_REFUSED   = 2'd1,
    ST_GIVEN     = 2'd2,
    ST_NOT_READY = 2'd3
  } status_e;

  typedef enum logic [CfgAddrW-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_SCALE  = 2'd2
  } reg_e;

  // One queued request, already split into its kind and its pixel.
  typedef struct packed {
    cmd_e            cmd;
    logic [PixW-1:0] pixel;
  } item_t;

  // Clamped configuration as the back end uses it.
  typedef struct packed {
    logic [CntW-1:0] width;
    logic [RowW-1:0] h_last;
    logic [RepW-1:0] s_last;
    logic            restart;
  } cfg_t;

endpackage

@@ rtl/puru_front.sv @@
module puru_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [puru_pkg::PixW-1:0]     s_axis_tdata,  // [7:0] source_pixel
  input  logic                          s_axis_tuser,  // [0] cmd
  output logic                          item_valid_o,
  output puru_pkg::item_t               item_o,
  input  logic                          pop_i
);

  puru_pkg::item_t                     fifo_q [puru_pkg::FifoDepth];
  logic [puru_pkg::PtrW-1:0]           wr_ptr_q, wr_ptr_d;
  logic [puru_pkg::PtrW-1:0]           rd_ptr_q, rd_ptr_d;
  logic [puru_pkg::FifoCntW-1:0]       cnt_q, cnt_d;
  logic                                push;
  logic                                pop;
  puru_pkg::item_t                     item_in;

  // Classify the incoming request.
  assign item_in.cmd   = puru_pkg::cmd_e'(s_axis_tuser);
  assign item_in.pixel = s_axis_tdata;

  assign s_axis_tready = (cnt_q != puru_pkg::FifoCntW'(puru_pkg::FifoDepth));
  assign item_valid_o  = (cnt_q != '0);
  assign item_o        = fifo_q[rd_ptr_q];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = item_valid_o && pop_i;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

@@ rtl/puru_back.sv @@
module puru_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  puru_pkg::cfg_t                  cfg_i,
  input  logic                            item_valid_i,
  input  puru_pkg::item_t                 item_i,
  output logic                            pop_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [puru_pkg::PixW-1:0]       m_axis_tdata,  // [7:0] out_pixel
  output logic                            m_axis_tlast,  // row_end
  output logic [puru_pkg::UserOutW-1:0]   m_axis_tuser   // [1:0] status, [2] frame_end
);

  logic [puru_pkg::PixW-1:0]  row_mem [puru_pkg::MaxWidth];

  logic [puru_pkg::CntW-1:0]  loaded_q, loaded_d;
  logic [puru_pkg::AddrW-1:0] col_q, col_d;
  logic [puru_pkg::RepW-1:0]  hrep_q, hrep_d;
  logic [puru_pkg::RepW-1:0]  vrep_q, vrep_d;
  logic [puru_pkg::RowW-1:0]  row_q, row_d;

  logic                       out_valid_q;
  puru_pkg::status_e          status_q, status_d;
  logic                       row_end_q, row_end_d;
  logic                       frame_end_q, frame_end_d;
  logic [puru_pkg::PixW-1:0]  rd_q;

  logic                       adv;
  logic                       take;
  logic                       wr_en;
  logic                       row_full;
  logic [puru_pkg::AddrW-1:0] w_last;
  logic                       hr_wrap, col_wrap, vr_wrap, row_wrap;

  // The output register frees up whenever it is empty or being drained.
  assign adv      = !out_valid_q || m_axis_tready;
  assign take     = item_valid_i && adv;
  assign pop_o    = adv;

  assign w_last   = puru_pkg::AddrW'(cfg_i.width - 1'b1);
  assign row_full = (loaded_q >= cfg_i.width);
  assign hr_wrap  = (hrep_q == cfg_i.s_last);
  assign col_wrap = (col_q == w_last);
  assign vr_wrap  = (vrep_q == cfg_i.s_last);
  assign row_wrap = (row_q == cfg_i.h_last);

  // Execute one queued request: store a pixel or step the replication counters; a restart clears them.
  always_comb begin
    loaded_d    = loaded_q;
    col_d       = col_q;
    hrep_d      = hrep_q;
    vrep_d      = vrep_q;
    row_d       = row_q;
    status_d    = puru_pkg::ST_NOT_READY;
    row_end_d   = 1'b0;
    frame_end_d = 1'b0;
    wr_en       = 1'b0;
    if (cfg_i.restart) begin
      loaded_d = '0;
      col_d    = '0;
      hrep_d   = '0;
      vrep_d   = '0;
      row_d    = '0;
    end else if (take) begin
      unique case (item_i.cmd)
        puru_pkg::CMD_LOAD: begin
          if (row_full) begin
            status_d = puru_pkg::ST_REFUSED;
          end else begin
            status_d = puru_pkg::ST_STORED;
            wr_en    = 1'b1;
            loaded_d = loaded_q + 1'b1;
          end
        end
        puru_pkg::CMD_REQUEST: begin
          if (row_full) begin
            status_d    = puru_pkg::ST_GIVEN;
            row_end_d   = col_wrap && hr_wrap;
            frame_end_d = col_wrap && hr_wrap && vr_wrap && row_wrap;
            if (!hr_wrap) begin
              hrep_d = hrep_q + 1'b1;
            end else begin
              hrep_d = '0;
              if (!col_wrap) begin
                col_d = col_q + 1'b1;
              end else begin
                col_d = '0;
                if (!vr_wrap) begin
                  vrep_d = vrep_q + 1'b1;
                end else begin
                  // Row fully given out: release the store for the next row.
                  vrep_d   = '0;
                  loaded_d = '0;
                  row_d    = row_wrap ? '0 : row_q + 1'b1;
                end
              end
            end
          end
        end
        default: begin
          status_d = puru_pkg::ST_NOT_READY;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q    <= '0;
      col_q       <= '0;
      hrep_q      <= '0;
      vrep_q      <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      loaded_q <= loaded_d;
      col_q    <= col_d;
      hrep_q   <= hrep_d;
      vrep_q   <= vrep_d;
      row_q    <= row_d;
      if (adv) begin
        out_valid_q <= item_valid_i;
      end
    end
  end

  // Row store and the registered output payload.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      row_mem[loaded_q[puru_pkg::AddrW-1:0]] <= item_i.pixel;
    end
    if (take) begin
      rd_q        <= row_mem[col_q];
      status_q    <= status_d;
      row_end_q   <= row_end_d;
      frame_end_q <= frame_end_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = (status_q == puru_pkg::ST_GIVEN) ? rd_q : '0;
  assign m_axis_tlast  = row_end_q;
  assign m_axis_tuser  = {frame_end_q, status_q};

`ifndef SYNTHESIS
  // The fill count never runs past the configured row width.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q <= cfg_i.width)
    else $error("row store fill count exceeds row width");

  // A frame end is always also a row end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && frame_end_q |-> row_end_q)
    else $error("frame end without row end");

  // Only given pixels carry end marks.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q != puru_pkg::ST_GIVEN) |-> !row_end_q && !frame_end_q)
    else $error("end mark on a result that is not a pixel");

  // A request against a partly loaded row reports not ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !cfg_i.restart && (item_i.cmd == puru_pkg::CMD_REQUEST) && !row_full
      |=> status_q == puru_pkg::ST_NOT_READY)
    else $error("pixel given before the row was complete");
`endif

endmodule

@@ rtl/pixel_replicating_upscaler_top.sv @@
// Nearest-neighbor integer upscaler for 8-bit grayscale frames.
// Input stream: tuser selects the request kind. With tuser low, tdata is the
// next source pixel (row-major) and is stored in the row store; with tuser
// high, the block returns the next output pixel of the upscaled frame.
// Every input request yields exactly one result on the output stream:
// tuser[1:0] is the status (stored, refused, pixel given, not ready),
// tuser[2] marks the frame end, tlast marks the end of an output row, and
// tdata carries the pixel, zero for non-pixel results.
// Each stored row is given out scale times, each pixel repeated scale times.
// Loads are refused while a complete row is still being given out.
// Configuration: index 0 width, 1 height, 2 scale; out-of-range values are
// clamped. A write restarts the frame and is meant for an idle block. Requests
// pass the queue, then the output register. One request is taken every cycle
// unless stalled; the rate is set by the counter update and the one row store
// read per request. A two-entry queue decouples input and execution.
// Reset empties the queue and output register and restarts the frame with
// width, height and scale set to one. When the receiver stalls, the result
// holds and the queue absorbs up to two more requests before tready drops.
module pixel_replicating_upscaler_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Source stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [puru_pkg::PixW-1:0]         s_axis_tdata,  // [7:0] source_pixel
  input  logic                              s_axis_tuser,  // [0] cmd
  // Result stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [puru_pkg::PixW-1:0]         m_axis_tdata,  // [7:0] out_pixel
  output logic                              m_axis_tlast,  // row_end
  output logic [puru_pkg::UserOutW-1:0]     m_axis_tuser,  // [1:0] status, [2] frame_end
  // Configuration writes.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [puru_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [puru_pkg::CfgDataW-1:0]     cfg_data_i
);

  logic [puru_pkg::CntW-1:0]  width_q, width_d;
  logic [puru_pkg::RowW-1:0]  h_last_q, h_last_d;
  logic [puru_pkg::RepW-1:0]  s_last_q, s_last_d;
  logic [puru_pkg::RepW:0]    scale_val;
  logic                       cfg_write;
  logic                       restart;
  puru_pkg::cfg_t             cfg;
  logic                       item_valid;
  puru_pkg::item_t            item;
  logic                       pop;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // Only the low five data bits carry the scale; higher write bits are dropped.
  assign scale_val   = cfg_data_i[puru_pkg::RepW:0];

  // Register decode with clamping into the usable range.
  always_comb begin
    width_d  = width_q;
    h_last_d = h_last_q;
    s_last_d = s_last_q;
    restart  = 1'b0;
    if (cfg_write) begin
      unique case (puru_pkg::reg_e'(cfg_addr_i))
        puru_pkg::REG_WIDTH: begin
          restart = 1'b1;
          if (cfg_data_i == '0) begin
            width_d = puru_pkg::CntW'(1);
          end else if (32'(cfg_data_i) > 32'(puru_pkg::MaxWidth)) begin
            width_d = puru_pkg::CntW'(puru_pkg::MaxWidth);
          end else begin
            width_d = puru_pkg::CntW'(cfg_data_i);
          end
        end
        puru_pkg::REG_HEIGHT: begin
          restart = 1'b1;
          if (cfg_data_i == '0) begin
            h_last_d = '0;
          end else if (32'(cfg_data_i) > 32'(puru_pkg::MaxHeight)) begin
            h_last_d = puru_pkg::RowW'(puru_pkg::MaxHeight - 1);
          end else begin
            h_last_d = puru_pkg::RowW'(cfg_data_i - 1'b1);
          end
        end
        puru_pkg::REG_SCALE: begin
          restart = 1'b1;
          if (scale_val == '0) begin
            s_last_d = '0;
          end else if (32'(scale_val) > 32'(puru_pkg::MaxScale)) begin
            s_last_d = puru_pkg::RepW'(puru_pkg::MaxScale - 1);
          end else begin
            s_last_d = puru_pkg::RepW'(scale_val - 1'b1);
          end
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= puru_pkg::CntW'(1);
      h_last_q <= '0;
      s_last_q <= '0;
    end else begin
      width_q  <= width_d;
      h_last_q <= h_last_d;
      s_last_q <= s_last_d;
    end
  end

  assign cfg.width   = width_q;
  assign cfg.h_last  = h_last_q;
  assign cfg.s_last  = s_last_q;
  assign cfg.restart = restart;

  puru_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .pop_i         (pop)
  );

  puru_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
